>>> design/xpf_pkg.sv
package xpf_pkg;

    localparam int NUM_W   = 48;
    localparam int LEN_W   = 12;
    localparam int IDX_W   = 11;
    // offset field wide enough for the largest supported group window (256)
    localparam int OFF_W   = 9;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    localparam logic [2:0] LEVEL_NONE = 3'd4;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FEC    = 2'd1,
        KIND_REVIVE = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_DUP      = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_FEC      = 3'd3,
        STAT_LONG     = 3'd4,
        STAT_NOREVIVE = 3'd5,
        STAT_SMALL    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SPAN,
        S_COUNT,
        S_QSCAN,
        S_FIN
    } bk_state_t;

    localparam logic REG_GROUP_BASE = 1'b0;

    typedef struct packed {
        kind_t              kind;
        logic [NUM_W-1:0]   pn;
        logic [1:0]         lvl;
        logic [LEN_W-1:0]   len;
        logic [IDX_W-1:0]   idx;
        logic [7:0]         data;
        logic               first;
        logic               last;
        logic               lt_base;
        logic               le_base;
        logic               off_lt_w;
        logic               off_gt_w;
        logic [OFF_W-1:0]   offv;
    } item_t;

endpackage

>>> design/xpf_front.sv
module xpf_front #(
    parameter int GROUP_WINDOW = 64
) (
    input  logic [1:0]              kind,
    input  logic [47:0]             pkt_number,
    input  logic [1:0]              enc_level,
    input  logic [11:0]             payload_length,
    input  logic [10:0]             byte_index,
    input  logic [7:0]              data_byte,
    input  logic                    first_byte,
    input  logic                    last_byte,
    input  logic [47:0]             group_base,
    output xpf_pkg::item_t          item
);
    import xpf_pkg::*;

    logic [NUM_W-1:0] off;

    // classify the word against the group base
    always_comb
    begin
        off           = pkt_number - group_base;
        item.kind     = kind_t'(kind);
        item.pn       = pkt_number;
        item.lvl      = enc_level;
        item.len      = payload_length;
        item.idx      = byte_index;
        item.data     = data_byte;
        item.first    = first_byte;
        item.last     = last_byte;
        item.lt_base  = pkt_number < group_base;
        item.le_base  = pkt_number <= group_base;
        item.off_lt_w = (off < NUM_W'(GROUP_WINDOW)) && !item.lt_base;
        item.off_gt_w = off > NUM_W'(GROUP_WINDOW);
        item.offv     = off[OFF_W-1:0];
    end

endmodule

>>> design/xpf_fifo.sv
module xpf_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  xpf_pkg::item_t  wdata,
    input  logic            pop,
    output xpf_pkg::item_t  head,
    output logic            full,
    output logic            empty
);
    import xpf_pkg::*;

    item_t               slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, wr_next;
    logic [QPTR_W-1:0]   rd_reg, rd_next;
    logic [QPTR_W:0]     cnt_reg, cnt_next;

    assign full  = cnt_reg == (QPTR_W+1)'(QDEPTH);
    assign empty = cnt_reg == '0;
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= wdata;
        end
    end

endmodule

>>> design/xpf_back.sv
module xpf_back #(
    parameter int MAX_PAYLOAD  = 2048,
    parameter int GROUP_WINDOW = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [47:0]         group_base,
    input  logic                cfg_we,
    input  xpf_pkg::item_t      head,
    input  logic                empty,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [2:0]          status,
    output logic [7:0]          parity_byte,
    output logic [47:0]         revived_number,
    output logic [11:0]         parity_length,
    output logic [6:0]          missing_count,
    output logic                can_revive,
    output logic                finished,
    output logic                waiting_before,
    output logic [2:0]          effective_level
);
    import xpf_pkg::*;

    localparam int W   = GROUP_WINDOW;
    localparam int IW  = $clog2(W);
    localparam int OW  = $clog2(W + 1);
    localparam int MW  = $clog2(W + 2);
    localparam int SW  = $clog2(W * W);
    localparam int AW  = $clog2(MAX_PAYLOAD);
    localparam int CH  = (W + 7) / 8;
    localparam int QW  = CH * 8;
    localparam int QCW = $clog2(CH + 1);

    bk_state_t          state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [W-1:0]       map_reg, map_next;
    logic [LEN_W-1:0]   plen_reg, plen_next;
    logic               fec_reg, fec_next;
    logic [NUM_W-1:0]   lp_reg, lp_next;
    logic [2:0]         lvl_reg, lvl_next;
    logic               pacc_reg, pacc_next;
    status_t            pstat_reg, pstat_next;
    logic [OW-1:0]      span_reg, span_next;
    logic [SW-1:0]      tri_reg, tri_next;
    logic [OW-1:0]      got_reg, got_next;
    logic [SW-1:0]      isum_reg, isum_next;
    logic [OW-1:0]      tot_reg, tot_next;
    logic [SW-1:0]      tsum_reg, tsum_next;
    logic [OW-1:0]      hi_reg, hi_next;
    logic               pend_reg, pend_next;
    logic [IW-1:0]      rc_reg, rc_next;
    logic [QW-1:0]      qmap_reg, qmap_next;
    logic [QCW-1:0]     qc_reg, qc_next;
    logic               wait_reg, wait_next;
    logic               cwr_reg, cwr_next;
    logic [AW-1:0]      caddr_reg, caddr_next;
    logic [7:0]         cdata_reg, cdata_next;
    status_t            cstat_reg, cstat_next;
    logic               cserved_reg, cserved_next;
    logic [NUM_W-1:0]   cnum_reg, cnum_next;
    logic               cpick_reg, cpick_next;
    logic               ov_reg, ov_next;
    status_t            ostat_reg;
    logic [7:0]         obyte_reg;
    logic [NUM_W-1:0]   onum_reg;
    logic [MW-1:0]      omiss_reg;
    logic               owait_reg;
    logic [LEN_W-1:0]   oplen_reg;
    logic [2:0]         olvl_reg;

    logic [7:0]         mem [MAX_PAYLOAD];
    logic [7:0]         rd_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [7:0]         mem_wdata;
    logic [AW-1:0]      mem_raddr;

    logic [MW-1:0]      miss;
    logic [IW-1:0]      offi;
    logic [OW-1:0]      offo;
    logic [IW-1:0]      mpos;
    status_t            dec;
    logic               acc;
    logic               idx_in_max;
    logic               len_long;
    logic               do_mark;
    logic [IW-1:0]      mark_i;
    logic [NUM_W:0]     span_sum;
    logic [SW-1:0]      pa, pb;
    logic               fin_go;
    logic [NUM_W-1:0]   fin_num;

    assign miss = fec_reg ? MW'(span_reg - got_reg) : MW'(W + 1);
    assign offo = head.offv[OW-1:0];
    assign offi = head.offv[IW-1:0];
    assign mpos = IW'(tri_reg - isum_reg);
    assign idx_in_max = {2'b00, head.idx} < 13'(MAX_PAYLOAD);
    assign len_long   = {1'b0, head.len} > 13'(MAX_PAYLOAD);
    assign fin_go     = !ov_reg || !result_stall;

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        map_next     = map_reg;
        plen_next    = plen_reg;
        fec_next     = fec_reg;
        lp_next      = lp_reg;
        lvl_next     = lvl_reg;
        pacc_next    = pacc_reg;
        pstat_next   = pstat_reg;
        span_next    = span_reg;
        tri_next     = tri_reg;
        got_next     = got_reg;
        isum_next    = isum_reg;
        tot_next     = tot_reg;
        tsum_next    = tsum_reg;
        hi_next      = hi_reg;
        pend_next    = pend_reg;
        rc_next      = rc_reg;
        qmap_next    = qmap_reg;
        qc_next      = qc_reg;
        wait_next    = wait_reg;
        cwr_next     = cwr_reg;
        caddr_next   = caddr_reg;
        cdata_next   = cdata_reg;
        cstat_next   = cstat_reg;
        cserved_next = cserved_reg;
        cnum_next    = cnum_reg;
        cpick_next   = cpick_reg;
        ov_next      = ov_reg && result_stall;
        pop          = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = caddr_reg;
        mem_wdata    = rd_reg ^ cdata_reg;
        mem_raddr    = caddr_reg;
        dec          = STAT_OK;
        acc          = 1'b0;
        do_mark      = 1'b0;
        mark_i       = offi;
        span_sum     = '0;
        pa           = '0;
        pb           = '0;
        fin_num      = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(MAX_PAYLOAD - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                mem_raddr = AW'(head.idx);
                if (pend_reg)
                begin
                    pend_next  = 1'b0;
                    state_next = S_SPAN;
                end
                else if (!empty)
                begin
                    pop          = 1'b1;
                    caddr_next   = AW'(head.idx);
                    cdata_next   = head.data;
                    cwr_next     = 1'b0;
                    cpick_next   = 1'b0;
                    cserved_next = 1'b0;
                    cstat_next   = STAT_OK;
                    wait_next    = 1'b0;
                    state_next   = S_FIN;
                    case (head.kind)
                        KIND_DATA, KIND_FEC:
                        begin
                            if (head.kind == KIND_DATA)
                            begin
                                if (head.lt_base || !head.off_lt_w)
                                    dec = STAT_RANGE;
                                else if (map_reg[offi])
                                    dec = STAT_DUP;
                                else if (fec_reg && head.pn > lp_reg)
                                    dec = STAT_RANGE;
                                else if (len_long)
                                    dec = STAT_LONG;
                                else
                                    dec = STAT_OK;
                            end
                            else
                            begin
                                if (fec_reg)
                                    dec = STAT_FEC;
                                else if (head.le_base || head.off_gt_w)
                                    dec = STAT_RANGE;
                                else if (hi_reg > offo)
                                    dec = STAT_FEC;
                                else if (len_long)
                                    dec = STAT_LONG;
                                else
                                    dec = STAT_OK;
                            end
                            if (head.first)
                            begin
                                pstat_next = dec;
                                acc        = dec == STAT_OK;
                                if (acc)
                                begin
                                    if (head.len > plen_reg)
                                        plen_next = head.len;
                                    if ({1'b0, head.lvl} < lvl_reg)
                                        lvl_next = {1'b0, head.lvl};
                                    if (head.kind == KIND_DATA)
                                    begin
                                        do_mark = 1'b1;
                                    end
                                    else
                                    begin
                                        fec_next  = 1'b1;
                                        lp_next   = head.pn - 1'b1;
                                        span_next = offo;
                                        pa        = SW'(offo);
                                        pb        = SW'(offo) - 1'b1;
                                        tri_next  = SW'((pa * pb) >> 1);
                                        got_next  = tot_reg;
                                        isum_next = tsum_reg;
                                    end
                                end
                            end
                            else
                            begin
                                acc = pacc_reg;
                            end
                            if (acc)
                            begin
                                cwr_next   = ({1'b0, head.idx} < head.len) && idx_in_max;
                                cstat_next = STAT_OK;
                            end
                            else
                            begin
                                cstat_next = head.first ? dec : pstat_reg;
                            end
                            pacc_next = head.last ? 1'b0 : acc;
                        end

                        KIND_REVIVE:
                        begin
                            if (miss != MW'(1))
                            begin
                                cstat_next = STAT_NOREVIVE;
                            end
                            else if (plen_reg > head.len)
                            begin
                                cstat_next = STAT_SMALL;
                            end
                            else
                            begin
                                cserved_next = 1'b1;
                                cnum_next    = group_base + NUM_W'(mpos);
                                cpick_next   = ({1'b0, head.idx} < plen_reg) && idx_in_max;
                                if (head.last)
                                begin
                                    do_mark = 1'b1;
                                    mark_i  = mpos;
                                end
                            end
                        end

                        KIND_QUERY:
                        begin
                            qc_next    = '0;
                            state_next = S_QSCAN;
                            qmap_next  = '0;
                            if (head.off_gt_w && !head.le_base)
                            begin
                                qmap_next[0] = 1'b1;
                            end
                            else if (!head.le_base)
                            begin
                                for (int i = 0; i < W; i++)
                                begin
                                    qmap_next[i] = (OW'(i) < offo) && !map_reg[i];
                                end
                            end
                        end

                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase

                    // record a newly received number
                    if (do_mark)
                    begin
                        map_next[mark_i] = 1'b1;
                        tot_next         = tot_reg + 1'b1;
                        tsum_next        = tsum_reg + SW'(mark_i);
                        if (OW'(mark_i) >= hi_reg)
                            hi_next = OW'(mark_i) + 1'b1;
                        if (fec_reg && (OW'(mark_i) < span_reg))
                        begin
                            got_next  = got_reg + 1'b1;
                            isum_next = isum_reg + SW'(mark_i);
                        end
                    end
                end
            end

            S_SPAN:
            begin
                span_sum = {1'b0, lp_reg - group_base} + 1'b1;
                if (span_sum[31:0] > 32'(W))
                    span_next = OW'(W);
                else
                    span_next = span_sum[OW-1:0];
                got_next   = '0;
                isum_next  = '0;
                rc_next    = '0;
                state_next = S_COUNT;
            end

            S_COUNT:
            begin
                pa       = SW'(span_reg);
                pb       = SW'(span_reg) - 1'b1;
                tri_next = SW'((pa * pb) >> 1);
                if (map_reg[rc_reg] && (OW'(rc_reg) < span_reg))
                begin
                    got_next  = got_reg + 1'b1;
                    isum_next = isum_reg + SW'(rc_reg);
                end
                rc_next = rc_reg + 1'b1;
                if (rc_reg == IW'(W - 1))
                    state_next = S_IDLE;
            end

            S_QSCAN:
            begin
                wait_next = wait_reg | (|qmap_reg[7:0]);
                qmap_next = qmap_reg >> 8;
                qc_next   = qc_reg + 1'b1;
                if (qc_reg == QCW'(CH - 1))
                    state_next = S_FIN;
            end

            S_FIN:
            begin
                if (fin_go)
                begin
                    mem_we     = cwr_reg;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cserved_reg)
            fin_num = cnum_reg;
        else if (miss == MW'(1))
            fin_num = group_base + NUM_W'(mpos);

        if (cfg_we)
            pend_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            map_reg     <= '0;
            plen_reg    <= '0;
            fec_reg     <= 1'b0;
            lp_reg      <= '0;
            lvl_reg     <= LEVEL_NONE;
            pacc_reg    <= 1'b0;
            pstat_reg   <= STAT_OK;
            span_reg    <= '0;
            tri_reg     <= '0;
            got_reg     <= '0;
            isum_reg    <= '0;
            tot_reg     <= '0;
            tsum_reg    <= '0;
            hi_reg      <= '0;
            pend_reg    <= 1'b0;
            rc_reg      <= '0;
            qc_reg      <= '0;
            wait_reg    <= 1'b0;
            cwr_reg     <= 1'b0;
            cserved_reg <= 1'b0;
            cpick_reg   <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            map_reg     <= map_next;
            plen_reg    <= plen_next;
            fec_reg     <= fec_next;
            lp_reg      <= lp_next;
            lvl_reg     <= lvl_next;
            pacc_reg    <= pacc_next;
            pstat_reg   <= pstat_next;
            span_reg    <= span_next;
            tri_reg     <= tri_next;
            got_reg     <= got_next;
            isum_reg    <= isum_next;
            tot_reg     <= tot_next;
            tsum_reg    <= tsum_next;
            hi_reg      <= hi_next;
            pend_reg    <= pend_next;
            rc_reg      <= rc_next;
            qc_reg      <= qc_next;
            wait_reg    <= wait_next;
            cwr_reg     <= cwr_next;
            cserved_reg <= cserved_next;
            cpick_reg   <= cpick_next;
            ov_reg      <= ov_next;
        end
    end

    // payload: current word and result word
    always_ff @(posedge clk)
    begin
        qmap_reg  <= qmap_next;
        caddr_reg <= caddr_next;
        cdata_reg <= cdata_next;
        cstat_reg <= cstat_next;
        cnum_reg  <= cnum_next;
        if (state_reg == S_FIN && fin_go)
        begin
            ostat_reg <= cstat_reg;
            obyte_reg <= cpick_reg ? rd_reg : 8'h00;
            onum_reg  <= fin_num;
            omiss_reg <= miss;
            owait_reg <= wait_reg;
            oplen_reg <= plen_reg;
            olvl_reg  <= lvl_reg;
        end
    end

    // parity store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[mem_raddr];
    end

    assign result_valid    = ov_reg;
    assign status          = ostat_reg;
    assign parity_byte     = obyte_reg;
    assign revived_number  = onum_reg;
    assign parity_length   = oplen_reg;
    assign missing_count   = 7'(omiss_reg);
    assign can_revive      = omiss_reg == MW'(1);
    assign finished        = omiss_reg == '0;
    assign waiting_before  = owait_reg;
    assign effective_level = olvl_reg;

endmodule

>>> design/xor_parity_fec_group_top.sv
// XOR parity FEC group. Data and FEC packet bytes, revive reads and
// waiting-before queries enter as words on the item channel; each gives one
// result word. A packet is judged on its first byte and every byte of an
// accepted packet that lies within its payload length is XORed into a
// parity RAM of MAX_PAYLOAD bytes. Words pass through a four-deep queue to
// an execution engine, so the input keeps accepting while a result waits,
// until the queue is full. Data, FEC and revive words each do a RAM read,
// then (data and FEC only) the XOR write-back, and the result, set by the
// single read-modify-write on the parity RAM; a query scans the received
// map one byte a cycle. After reset the RAM is swept to zero before the
// first word executes (words still queue). A write of group_base starts a
// recount of the received map. parity_length and effective_level are
// captured with the rest of the result word and hold while it waits.
module xor_parity_fec_group_top #(
    parameter int MAX_PAYLOAD  = 2048,
    parameter int GROUP_WINDOW = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready,
    input  logic            item_valid,
    output logic            item_stall,
    input  logic [1:0]      kind,
    input  logic [47:0]     pkt_number,
    input  logic [1:0]      enc_level,
    input  logic [11:0]     payload_length,
    input  logic [10:0]     byte_index,
    input  logic [7:0]      data_byte,
    input  logic            first_byte,
    input  logic            last_byte,
    output logic            result_valid,
    input  logic            result_stall,
    output logic [2:0]      status,
    output logic [7:0]      parity_byte,
    output logic [47:0]     revived_number,
    output logic [11:0]     parity_length,
    output logic [6:0]      missing_count,
    output logic            can_revive,
    output logic            finished,
    output logic            waiting_before,
    output logic [2:0]      effective_level
);
    import xpf_pkg::*;

    logic [NUM_W-1:0]   base_reg;
    logic               cfg_we;
    item_t              item;
    item_t              head;
    logic               full;
    logic               empty;
    logic               pop;

    // register file: group_base only, selected when paddr[3] is low
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[3] == REG_GROUP_BASE);
    assign prdata = (paddr[3] == REG_GROUP_BASE) ? {16'h0000, base_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            base_reg <= pwdata[NUM_W-1:0];
        end
    end

    // front: classify the arriving word against the group base
    xpf_front #(
        .GROUP_WINDOW (GROUP_WINDOW)
    ) u_front (
        .kind             (kind),
        .pkt_number       (pkt_number),
        .enc_level        (enc_level),
        .payload_length   (payload_length),
        .byte_index       (byte_index),
        .data_byte        (data_byte),
        .first_byte       (first_byte),
        .last_byte        (last_byte),
        .group_base       (base_reg),
        .item             (item)
    );

    // queue words until the engine is free; stall the input while the queue is full
    assign item_stall = full;

    xpf_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_valid && !full),
        .wdata (item),
        .pop   (pop),
        .head  (head),
        .full  (full),
        .empty (empty)
    );

    // back: decide, update group state, drive the parity RAM and the result
    xpf_back #(
        .MAX_PAYLOAD  (MAX_PAYLOAD),
        .GROUP_WINDOW (GROUP_WINDOW)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .group_base      (base_reg),
        .cfg_we          (cfg_we),
        .head            (head),
        .empty           (empty),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .parity_byte     (parity_byte),
        .revived_number  (revived_number),
        .parity_length   (parity_length),
        .missing_count   (missing_count),
        .can_revive      (can_revive),
        .finished        (finished),
        .waiting_before  (waiting_before),
        .effective_level (effective_level)
    );

endmodule
